// ----- rtl/tlr_pkg.sv -----
// Shared constants and types for the thick line rasteriser.
package tlr_pkg;

    // Default coordinate width of the line endpoints.
    localparam int COORD_BITS_DEF = 11;
    // Default largest brush width that the clamp lets through.
    localparam int BRUSH_MAX_DEF = 63;
    // Width of the brush width register.
    localparam int WIDTH_BITS = 6;
    // Largest value the brush width register can hold.
    localparam int WIDTH_MAX = (1 << WIDTH_BITS) - 1;
    // Width of an emitted pixel coordinate.
    localparam int PIX_BITS = 12;
    // Default width of a signed brush offset for the default brush clamp.
    localparam int OFF_BITS_DEF = $clog2(BRUSH_MAX_DEF / 2 + 1) + 1;
    // Reset value of the brush width register.
    localparam logic [WIDTH_BITS-1:0] BRUSH_WIDTH_RESET = WIDTH_BITS'(1);

    // Opcodes carried in the input tuser.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Commands from the handshake logic to the walker.
    typedef struct packed {
        logic load;
        logic step;
    } tlr_cmd_t;

    // Walker status towards the handshake logic.
    typedef struct packed {
        logic busy;
        logic emit;
    } tlr_stat_t;

    // One emitted pixel.
    typedef struct packed {
        logic                last;
        logic [PIX_BITS-1:0] y;
        logic [PIX_BITS-1:0] x;
    } tlr_pix_t;

endpackage

// ----- rtl/thick_line_rasterizer.sv -----
// Top level of the thick line rasteriser: stream ports, brush register, output register.
//
// Send a load beat (tuser low) with both endpoints, then one step beat (tuser high) for each
// pixel wanted. Every step beat while a line is active produces exactly one pixel beat, in
// the cycle after it is accepted; loads and steps after the end produce nothing. For each
// line point in Bresenham order a square of (2*(w/2)+1) pixels per side is emitted, w =
// brush_width clamped to BRUSH_MAX, x offset outer, y offset inner, and tlast marks the
// final pixel at the end point. The block takes one beat per clock unless output stalls: the
// walker updates point, error term and brush offsets per beat, and the output register lets
// a new beat in while a pixel is taken. Write brush_width only while no line is in flight.
module thick_line_rasterizer #(
    parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF,
    parameter int BRUSH_MAX  = tlr_pkg::BRUSH_MAX_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration: brush width.
    input  logic                                   cfg_we,
    input  logic [tlr_pkg::WIDTH_BITS-1:0]         cfg_wdata,
    // Input stream.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // Fields from bit 0: start_x, start_y, end_x, end_y, then zero padding.
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // Fields from bit 0: opcode.
    input  logic                                   s_axis_tuser,
    // Output stream.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // Fields from bit 0: pixel_x, pixel_y.
    output logic [2*tlr_pkg::PIX_BITS-1:0]         m_axis_tdata,
    output logic                                   m_axis_tlast
);
    import tlr_pkg::*;

    localparam int C        = COORD_BITS;
    localparam int WMAX     = (BRUSH_MAX < WIDTH_MAX) ? BRUSH_MAX : WIDTH_MAX;
    localparam int OFF_BITS = $clog2(WMAX / 2 + 1) + 1;
    localparam logic [WIDTH_BITS-1:0] WMAX_V = WIDTH_BITS'(WMAX);

    logic [WIDTH_BITS-1:0]      brush_width_reg;
    logic [WIDTH_BITS-1:0]      width_clip;
    logic signed [OFF_BITS-1:0] half;
    logic                       accept;
    tlr_cmd_t                   cmd;
    tlr_pix_t                   pix;
    tlr_stat_t                  stat;
    logic                       out_valid_reg, out_valid_next;
    tlr_pix_t                   out_pix_reg;

    // Brush width register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brush_width_reg <= BRUSH_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            brush_width_reg <= cfg_wdata;
        end
    end

    // Clamp the width and halve it to get the brush half-size.
    always_comb
    begin
        width_clip = (brush_width_reg > WMAX_V) ? WMAX_V : brush_width_reg;
        half       = OFF_BITS'(width_clip >> 1);
    end

    // Input handshake: a beat enters whenever the output register is free or draining.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cmd.load      = accept && (s_axis_tuser == OP_LOAD);
    assign cmd.step      = accept && (s_axis_tuser == OP_STEP);

    tlr_walk #(
        .COORD_BITS (COORD_BITS),
        .OFF_BITS   (OFF_BITS)
    ) u_walk (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .start_x ($signed(s_axis_tdata[C-1:0])),
        .start_y ($signed(s_axis_tdata[2*C-1:C])),
        .end_x   ($signed(s_axis_tdata[3*C-1:2*C])),
        .end_y   ($signed(s_axis_tdata[4*C-1:3*C])),
        .half    (half),
        .pix     (pix),
        .stat    (stat)
    );

    // Output register: reloads whenever the previous beat has gone or was never there.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s_axis_tready)
        begin
            out_valid_next = stat.emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.emit)
        begin
            out_pix_reg <= pix;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_pix_reg.y, out_pix_reg.x};
    assign m_axis_tlast  = out_pix_reg.last;

    // A load never produces a pixel beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !m_axis_tvalid)
        else $error("pixel beat appeared after a load");

    // A step taken during a line always produces a pixel beat in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && stat.busy) |=> m_axis_tvalid)
        else $error("step during a line produced no pixel");

    // The final pixel of a line is only shown once the walker has gone idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> !stat.busy)
        else $error("last pixel shown while the line is still active");

endmodule

// ----- rtl/tlr_walk.sv -----
// Bresenham line walker with square brush offsets, one pixel per step.
module tlr_walk #(
    parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF,
    parameter int OFF_BITS   = tlr_pkg::OFF_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tlr_pkg::tlr_cmd_t             cmd,
    input  logic signed [COORD_BITS-1:0]  start_x,
    input  logic signed [COORD_BITS-1:0]  start_y,
    input  logic signed [COORD_BITS-1:0]  end_x,
    input  logic signed [COORD_BITS-1:0]  end_y,
    input  logic signed [OFF_BITS-1:0]    half,
    output tlr_pkg::tlr_pix_t             pix,
    output tlr_pkg::tlr_stat_t            stat
);
    import tlr_pkg::*;

    localparam int C        = COORD_BITS;
    localparam int SUM_BITS = (C > PIX_BITS) ? C : PIX_BITS;
    localparam logic signed [C-1:0] ONE     = C'(1);
    localparam logic signed [C-1:0] MIN_ONE = -ONE;

    // Walk state.
    logic signed [C-1:0]        walk_x_reg, walk_x_next;
    logic signed [C-1:0]        walk_y_reg, walk_y_next;
    logic signed [C-1:0]        target_x_reg, target_x_next;
    logic signed [C-1:0]        target_y_reg, target_y_next;
    logic [C-1:0]               span_x_reg, span_x_next;
    logic [C-1:0]               span_y_reg, span_y_next;
    logic                       dir_x_neg_reg, dir_x_neg_next;
    logic                       dir_y_neg_reg, dir_y_neg_next;
    logic signed [C+1:0]        err_reg, err_next;
    logic signed [OFF_BITS-1:0] off_x_reg, off_x_next;
    logic signed [OFF_BITS-1:0] off_y_reg, off_y_next;
    logic                       busy_reg, busy_next;

    // Load-time differences.
    logic signed [C:0]   diff_x, diff_y;
    logic signed [C:0]   abs_x, abs_y;
    logic [C-1:0]        span_x_ld, span_y_ld;

    // Bresenham decision terms.
    logic signed [C+2:0] err_dbl, neg_span_y, pos_span_x;
    logic                move_x, move_y;
    logic signed [C+1:0] err_adj;
    logic                at_end;
    logic                emit;
    logic                last;

    // Pixel sums before wrapping to the output width.
    logic signed [SUM_BITS-1:0] sum_x, sum_y;
    logic signed [OFF_BITS-1:0] neg_half;

    // Endpoint differences and their magnitudes for a load.
    always_comb
    begin
        diff_x    = (C+1)'(end_x) - (C+1)'(start_x);
        diff_y    = (C+1)'(end_y) - (C+1)'(start_y);
        abs_x     = diff_x[C] ? -diff_x : diff_x;
        abs_y     = diff_y[C] ? -diff_y : diff_y;
        span_x_ld = abs_x[C-1:0];
        span_y_ld = abs_y[C-1:0];
    end

    // Error doubling and the two axis decisions.
    always_comb
    begin
        err_dbl    = $signed({err_reg, 1'b0});
        neg_span_y = -$signed({3'b000, span_y_reg});
        pos_span_x = $signed({3'b000, span_x_reg});
        move_x     = err_dbl > neg_span_y;
        move_y     = err_dbl < pos_span_x;
        err_adj    = err_reg;
        if (move_x)
        begin
            err_adj = err_adj - $signed({2'b00, span_y_reg});
        end
        if (move_y)
        begin
            err_adj = err_adj + $signed({2'b00, span_x_reg});
        end
        at_end = (walk_x_reg == target_x_reg) && (walk_y_reg == target_y_reg);
    end

    assign neg_half = -half;
    assign emit     = cmd.step && busy_reg;

    // Next state: load, or advance the brush and the line point on a step.
    always_comb
    begin
        walk_x_next    = walk_x_reg;
        walk_y_next    = walk_y_reg;
        target_x_next  = target_x_reg;
        target_y_next  = target_y_reg;
        span_x_next    = span_x_reg;
        span_y_next    = span_y_reg;
        dir_x_neg_next = dir_x_neg_reg;
        dir_y_neg_next = dir_y_neg_reg;
        err_next       = err_reg;
        off_x_next     = off_x_reg;
        off_y_next     = off_y_reg;
        busy_next      = busy_reg;
        last           = 1'b0;
        if (cmd.load)
        begin
            walk_x_next    = start_x;
            walk_y_next    = start_y;
            target_x_next  = end_x;
            target_y_next  = end_y;
            span_x_next    = span_x_ld;
            span_y_next    = span_y_ld;
            dir_x_neg_next = diff_x[C];
            dir_y_neg_next = diff_y[C];
            err_next       = $signed({2'b00, span_x_ld}) - $signed({2'b00, span_y_ld});
            off_x_next     = neg_half;
            off_y_next     = neg_half;
            busy_next      = 1'b1;
        end
        else if (emit)
        begin
            if (off_y_reg >= half)
            begin
                off_y_next = neg_half;
                if (off_x_reg >= half)
                begin
                    off_x_next = neg_half;
                    if (at_end)
                    begin
                        last      = 1'b1;
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        err_next = err_adj;
                        if (move_x)
                        begin
                            walk_x_next = walk_x_reg + (dir_x_neg_reg ? MIN_ONE : ONE);
                        end
                        if (move_y)
                        begin
                            walk_y_next = walk_y_reg + (dir_y_neg_reg ? MIN_ONE : ONE);
                        end
                    end
                end
                else
                begin
                    off_x_next = off_x_reg + OFF_BITS'(1);
                end
            end
            else
            begin
                off_y_next = off_y_reg + OFF_BITS'(1);
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_x_reg    <= '0;
            walk_y_reg    <= '0;
            target_x_reg  <= '0;
            target_y_reg  <= '0;
            span_x_reg    <= '0;
            span_y_reg    <= '0;
            dir_x_neg_reg <= 1'b0;
            dir_y_neg_reg <= 1'b0;
            err_reg       <= '0;
            off_x_reg     <= '0;
            off_y_reg     <= '0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            walk_x_reg    <= walk_x_next;
            walk_y_reg    <= walk_y_next;
            target_x_reg  <= target_x_next;
            target_y_reg  <= target_y_next;
            span_x_reg    <= span_x_next;
            span_y_reg    <= span_y_next;
            dir_x_neg_reg <= dir_x_neg_next;
            dir_y_neg_reg <= dir_y_neg_next;
            err_reg       <= err_next;
            off_x_reg     <= off_x_next;
            off_y_reg     <= off_y_next;
            busy_reg      <= busy_next;
        end
    end

    // The pixel is the line point plus the brush offset, wrapped to the output width.
    always_comb
    begin
        sum_x    = SUM_BITS'(walk_x_reg) + SUM_BITS'(off_x_reg);
        sum_y    = SUM_BITS'(walk_y_reg) + SUM_BITS'(off_y_reg);
        pix.x    = sum_x[PIX_BITS-1:0];
        pix.y    = sum_y[PIX_BITS-1:0];
        pix.last = last;
    end

    assign stat.busy = busy_reg;
    assign stat.emit = emit;

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the thick line rasteriser: directed table, then random phases.
`timescale 1ns / 100ps

module testbench;

    import tlr_pkg::*;

    localparam int COORD_W     = COORD_BITS_DEF;
    localparam int DATA_W      = ((4 * COORD_W + 7) / 8) * 8;
    localparam int RANDOM_BEATS = 450;
    localparam int PHASE_BEATS  = 45;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_CAP    = 100;

    // Kinds of row in the directed table.
    typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic                    op;
        logic [COORD_W-1:0]      sx;
        logic [COORD_W-1:0]      sy;
        logic [COORD_W-1:0]      ex;
        logic [COORD_W-1:0]      ey;
        logic                    typed;
        tlr_pix_t                want;
        logic [WIDTH_BITS-1:0]   width;
    } stim_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [WIDTH_BITS-1:0]     cfg_wdata = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [DATA_W-1:0]         s_axis_tdata = '0;
    logic                      s_axis_tuser = OP_LOAD;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [2*PIX_BITS-1:0]     m_axis_tdata;
    logic                      m_axis_tlast;

    // Run control and statistics.
    logic                      idling = 1'b1;
    int                        fault_count = 0;
    int                        cycle_count = 0;
    int                        pixels_checked = 0;
    int                        lines_done = 0;
    int                        loads_seen = 0;
    int                        widths_written = 0;
    int                        beats_effective = 0;

    // Pixels predicted but not yet seen on the output, oldest first.
    tlr_pix_t                  pixels_due[$];
    stim_row_t                 plan[$];

    // Mirror of the rasteriser state.
    logic [WIDTH_BITS-1:0]     brush_width_q = BRUSH_WIDTH_RESET;
    logic signed [COORD_W-1:0] walk_x = '0;
    logic signed [COORD_W-1:0] walk_y = '0;
    logic signed [COORD_W-1:0] target_x = '0;
    logic signed [COORD_W-1:0] target_y = '0;
    logic [COORD_W-1:0]        span_x = '0;
    logic [COORD_W-1:0]        span_y = '0;
    logic                      dir_x_neg = 1'b0;
    logic                      dir_y_neg = 1'b0;
    logic signed [12:0]        error_term = '0;
    logic signed [6:0]         brush_off_x = '0;
    logic signed [6:0]         brush_off_y = '0;
    logic                      line_busy = 1'b0;

    thick_line_rasterizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock with an 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Print a fault on one line and count it; printing stops after a cap so a broken
    // design cannot flood the log.
    task automatic report_fault(input string msg);
        if (fault_count < PRINT_CAP)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        fault_count++;
    endtask

    // Pack the four endpoint fields into the input beat, start_x lowest.
    function automatic logic [DATA_W-1:0] pack_coords(input int sx, input int sy,
                                                      input int ex, input int ey);
        return DATA_W'({COORD_W'(ey), COORD_W'(ex), COORD_W'(sy), COORD_W'(sx)});
    endfunction

    function automatic int clamp_coord(input int v);
        if (v > 1023)
            return 1023;
        if (v < -1024)
            return -1024;
        return v;
    endfunction

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // Directed table rows.
    function automatic stim_row_t beat_row(input logic op, input int sx, input int sy,
                                           input int ex, input int ey);
        stim_row_t r;
        r = '0;
        r.kind = ROW_BEAT;
        r.op = op;
        r.sx = COORD_W'(sx);
        r.sy = COORD_W'(sy);
        r.ex = COORD_W'(ex);
        r.ey = COORD_W'(ey);
        return r;
    endfunction

    // A step whose pixel is written straight into the table.
    function automatic stim_row_t pixel_row(input int x, input int y, input logic last);
        stim_row_t r;
        r = beat_row(OP_STEP, 0, 0, 0, 0);
        r.typed = 1'b1;
        r.want.x = PIX_BITS'(x);
        r.want.y = PIX_BITS'(y);
        r.want.last = last;
        return r;
    endfunction

    function automatic stim_row_t width_row(input int w);
        stim_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.width = WIDTH_BITS'(w);
        return r;
    endfunction

    // Predict the effect of one accepted input beat on the rasteriser.
    task automatic raster_step(input logic op, input logic [DATA_W-1:0] data,
                               output logic emitted, output tlr_pix_t pix);
        int half, x0, y0, x1, y1, e2, sx, sy, ox, oy, err;
        logic done;
        half = brush_width_q / 2;
        emitted = 1'b0;
        pix = '0;
        done = 1'b0;
        if (op == OP_LOAD)
        begin
            // A load restarts the walk at the start point, even in the middle of a line.
            x0 = $signed(data[COORD_W-1:0]);
            y0 = $signed(data[2*COORD_W-1:COORD_W]);
            x1 = $signed(data[3*COORD_W-1:2*COORD_W]);
            y1 = $signed(data[4*COORD_W-1:3*COORD_W]);
            walk_x = COORD_W'(x0);
            walk_y = COORD_W'(y0);
            target_x = COORD_W'(x1);
            target_y = COORD_W'(y1);
            sx = (x1 >= x0) ? x1 - x0 : x0 - x1;
            sy = (y1 >= y0) ? y1 - y0 : y0 - y1;
            span_x = COORD_W'(sx);
            span_y = COORD_W'(sy);
            dir_x_neg = !(x1 >= x0);
            dir_y_neg = !(y1 >= y0);
            error_term = 13'(sx - sy);
            brush_off_x = 7'(-half);
            brush_off_y = 7'(-half);
            line_busy = 1'b1;
            loads_seen++;
            beats_effective++;
        end
        else if (line_busy)
        begin
            beats_effective++;
            emitted = 1'b1;
            ox = brush_off_x;
            oy = brush_off_y;
            pix.x = PIX_BITS'(int'(walk_x) + ox);
            pix.y = PIX_BITS'(int'(walk_y) + oy);
            // The y offset runs inner, the x offset outer, then the line point moves on.
            if (oy >= half)
            begin
                brush_off_y = 7'(-half);
                if (ox >= half)
                begin
                    brush_off_x = 7'(-half);
                    if (walk_x == target_x && walk_y == target_y)
                    begin
                        done = 1'b1;
                        line_busy = 1'b0;
                    end
                    else
                    begin
                        err = error_term;
                        sx = span_x;
                        sy = span_y;
                        e2 = 2 * err;
                        if (e2 > -sy)
                        begin
                            err = err - sy;
                            walk_x = COORD_W'(dir_x_neg ? int'(walk_x) - 1 : int'(walk_x) + 1);
                        end
                        if (e2 < sx)
                        begin
                            err = err + sx;
                            walk_y = COORD_W'(dir_y_neg ? int'(walk_y) - 1 : int'(walk_y) + 1);
                        end
                        error_term = 13'(err);
                    end
                end
                else
                    brush_off_x = 7'(ox + 1);
            end
            else
                brush_off_y = 7'(oy + 1);
            pix.last = done;
        end
    endtask

    // Offer one beat on the input, with random gaps, and predict it once accepted.
    task automatic send_beat(input logic op, input logic [DATA_W-1:0] data,
                             input logic typed, input tlr_pix_t want);
        logic emitted;
        tlr_pix_t pix;
        while (idling && $urandom_range(0, 99) < 28)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= data;
        do
            @(posedge clk);
        while (!s_axis_tready);
        raster_step(op, data, emitted, pix);
        if (typed)
            pixels_due.push_back(want);
        else if (emitted)
            pixels_due.push_back(pix);
        @(negedge clk);
    endtask

    task automatic send_load(input int x0, input int y0, input int x1, input int y1);
        send_beat(OP_LOAD, pack_coords(x0, y0, x1, y1), 1'b0, '0);
    endtask

    // Steps carry random coordinates, which the block must ignore.
    task automatic send_steps(input int n);
        repeat (n)
            send_beat(OP_STEP, pack_coords($urandom, $urandom, $urandom, $urandom),
                      1'b0, '0);
    endtask

    // Let every predicted pixel drain, give the output stage time to settle, then
    // write the brush width.
    task automatic write_width(input logic [WIDTH_BITS-1:0] w);
        s_axis_tvalid <= 1'b0;
        while (pixels_due.size() != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_we <= 1'b0;
        brush_width_q = w;
        widths_written++;
    endtask

    // One random episode: mostly a short line stepped towards its end, sometimes noise.
    task automatic run_episode();
        int kind, half, side, reach, x0, y0, x1, y1, points, pixels;
        half = brush_width_q / 2;
        side = 2 * half + 1;
        kind = $urandom_range(0, 99);
        x0 = $urandom_range(0, 2047);
        x0 = x0 - 1024;
        y0 = $urandom_range(0, 2047);
        y0 = y0 - 1024;
        if (kind < 75)
        begin
            // Short line sized so that small brushes usually reach the end point.
            reach = (half == 0) ? 7 : (half == 1) ? 3 : (half == 2) ? 1 : 0;
            x1 = $urandom_range(0, 2 * reach);
            x1 = clamp_coord(x0 + x1 - reach);
            y1 = $urandom_range(0, 2 * reach);
            y1 = clamp_coord(y0 + y1 - reach);
            points = magnitude(x1 - x0);
            if (magnitude(y1 - y0) > points)
                points = magnitude(y1 - y0);
            pixels = (points + 1) * side * side;
            if (pixels > 80)
                pixels = 80 + $urandom_range(0, 5);
            else
                pixels = pixels + $urandom_range(0, 2);
            send_load(x0, y0, x1, y1);
            send_steps(pixels);
        end
        else if (kind < 85)
        begin
            // Endpoints pinned to the edges of the coordinate range.
            x0 = $urandom_range(0, 1) ? 1023 : -1024;
            y0 = $urandom_range(0, 1) ? 1023 : -1024;
            x1 = $urandom_range(0, 1) ? -x0 - 1 : x0;
            y1 = $urandom_range(0, 1) ? -y0 - 1 : y0;
            send_load(x0, y0, x1, y1);
            send_steps($urandom_range(1, 10));
        end
        else if (kind < 93)
            send_steps($urandom_range(1, 3));
        else
        begin
            // A line cut short; the next load abandons it.
            x1 = $urandom_range(0, 2047);
            y1 = $urandom_range(0, 2047);
            send_load(x0, y0, x1 - 1024, y1 - 1024);
            send_steps($urandom_range(0, 3));
        end
    endtask

    // Output side: random back-pressure.
    always @(negedge clk)
        m_axis_tready <= (idling && $urandom_range(0, 99) < 28) ? 1'b0 : 1'b1;

    // Compare every accepted output beat with the oldest predicted pixel.
    always @(posedge clk)
    begin : check_pixels
        tlr_pix_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pixels_due.size() == 0)
                report_fault($sformatf("unexpected pixel x=%0d y=%0d last=%0d",
                                       $signed(m_axis_tdata[PIX_BITS-1:0]),
                                       $signed(m_axis_tdata[2*PIX_BITS-1:PIX_BITS]),
                                       m_axis_tlast));
            else
            begin
                want = pixels_due.pop_front();
                if (m_axis_tdata[PIX_BITS-1:0] !== want.x)
                    report_fault($sformatf("pixel %0d x: got %0d expected %0d",
                                           pixels_checked,
                                           $signed(m_axis_tdata[PIX_BITS-1:0]),
                                           $signed(want.x)));
                if (m_axis_tdata[2*PIX_BITS-1:PIX_BITS] !== want.y)
                    report_fault($sformatf("pixel %0d y: got %0d expected %0d",
                                           pixels_checked,
                                           $signed(m_axis_tdata[2*PIX_BITS-1:PIX_BITS]),
                                           $signed(want.y)));
                if (m_axis_tlast !== want.last)
                    report_fault($sformatf("pixel %0d last: got %0b expected %0b",
                                           pixels_checked, m_axis_tlast, want.last));
                pixels_checked++;
                if (want.last)
                    lines_done++;
            end
        end
    end

    // Watchdog on the cycle count.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d pixels outstanding.",
                 cycle_count, pixels_due.size());
        $display("TEST FAILED");
        $finish;
    end

    // Main sequence: reset, directed table, random phases, drain and verdict.
    initial
    begin : main_flow
        int goal, stretch_start, phase, phase_start;
        int phase_widths[9];
        phase_widths = '{0, 1, 2, 3, 63, 5, 1, 4, 2};

        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table: step while idle after reset, a point line, full-range
        // diagonals, a load that abandons a line, a shallow line walked to its end,
        // a width change in mid-line including the zero width, and the widest brush.
        plan.push_back(beat_row(OP_STEP, 0, 0, 0, 0));
        plan.push_back(beat_row(OP_LOAD, 0, 0, 0, 0));
        plan.push_back(pixel_row(0, 0, 1'b1));
        plan.push_back(beat_row(OP_STEP, 0, 0, 0, 0));
        plan.push_back(beat_row(OP_LOAD, -1024, -1024, 1023, 1023));
        plan.push_back(pixel_row(-1024, -1024, 1'b0));
        plan.push_back(beat_row(OP_STEP, 0, 0, 0, 0));
        plan.push_back(beat_row(OP_LOAD, 1023, -1024, -1024, 1023));
        plan.push_back(pixel_row(1023, -1024, 1'b0));
        plan.push_back(beat_row(OP_STEP, 0, 0, 0, 0));
        plan.push_back(beat_row(OP_LOAD, 3, 1, -1, 2));
        repeat (5)
            plan.push_back(beat_row(OP_STEP, 0, 0, 0, 0));
        plan.push_back(width_row(2));
        plan.push_back(beat_row(OP_LOAD, 0, 0, 1, 0));
        plan.push_back(pixel_row(-1, -1, 1'b0));
        plan.push_back(beat_row(OP_STEP, 0, 0, 0, 0));
        plan.push_back(width_row(0));
        repeat (3)
            plan.push_back(beat_row(OP_STEP, 0, 0, 0, 0));
        plan.push_back(width_row(WIDTH_MAX));
        plan.push_back(beat_row(OP_LOAD, 1023, 1023, 1023, 1023));
        plan.push_back(pixel_row(992, 992, 1'b0));
        plan.push_back(pixel_row(992, 993, 1'b0));

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                write_width(plan[i].width);
            else
                send_beat(plan[i].op,
                          pack_coords(plan[i].sx, plan[i].sy, plan[i].ex, plan[i].ey),
                          plan[i].typed, plan[i].want);
        end

        // Random phases, each with its own brush width; one stretch runs without gaps.
        goal = beats_effective + RANDOM_BEATS;
        stretch_start = beats_effective + 150;
        phase = 0;
        while (beats_effective < goal)
        begin
            if (phase < 9)
                write_width(WIDTH_BITS'(phase_widths[phase]));
            else
                write_width(WIDTH_BITS'($urandom_range(1, WIDTH_MAX)));
            phase++;
            phase_start = beats_effective;
            while (beats_effective - phase_start < PHASE_BEATS && beats_effective < goal)
            begin
                idling = !(beats_effective >= stretch_start &&
                           beats_effective < stretch_start + 80);
                run_episode();
            end
        end
        idling = 1'b1;

        // Drain and let the output stage settle.
        s_axis_tvalid <= 1'b0;
        while (pixels_due.size() != 0)
            @(negedge clk);
        repeat (8)
            @(negedge clk);
        if (pixels_due.size() != 0)
            report_fault($sformatf("%0d pixels never arrived", pixels_due.size()));

        $display("Loaded %0d lines under %0d brush width settings; %0d pixels checked.",
                 loads_seen, widths_written, pixels_checked);
        $display("Lines walked to their end point: %0d; faults: %0d.",
                 lines_done, fault_count);
        if (fault_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/tlr_pkg.sv
rtl/tlr_walk.sv
rtl/thick_line_rasterizer.sv
dv/testbench.sv
